// ===== src/tcec_pkg.sv =====
// Shared types, constants and helper functions of the conductivity converter.
package tcec_pkg;

   // Field widths of the words and of the configuration register.
   localparam int ADC_W      = 10;
   localparam int TEMP_W     = 12;
   localparam int OFFSET_W   = 12;
   localparam int EC_W       = 16;
   localparam int STATUS_W   = 2;

   // Accumulator widths and group size.
   localparam int SUM_W           = 15;
   localparam int CNT_W           = 5;
   localparam int SAMPLES_DEFAULT = 20;

   // Calibration offset after reset, in uS/cm.
   localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 12'sd150;

   // The coefficient is D / 32000 with D = 37 * T + 17200, T in 1/16 degC.
   localparam int D_W = 18;
   localparam logic signed [D_W-1:0] D_SLOPE = 18'sd37;
   localparam logic signed [D_W-1:0] D_BIAS  = 18'sd17200;

   // The dividend sum * 10240000000 is built as (sum * 78125) << 17.
   localparam int PROD_W     = 32;
   localparam int VOLT_MULT  = 78125;
   localparam int VOLT_SHIFT = 17;

   // Serial restoring divider for the compensated voltage.
   localparam int NUM_W       = PROD_W + VOLT_SHIFT;
   localparam int DIVR_W      = 22;
   localparam int DCNT_W      = $clog2(NUM_W + 1);
   localparam int DIV1_STEPS  = NUM_W;

   // The final divide by 100 is a multiply by ceil(2^28 / 100) and a shift,
   // which is exact for every dividend below 2^21.
   localparam int Y_W         = 22;
   localparam int RECIP_W     = 2 * Y_W;
   localparam int RECIP_SHIFT = 28;
   localparam logic [Y_W-1:0] SEG_RECIP = 22'd2684355;

   // Compensated voltage limits in Q16 millivolts.
   localparam int V_W = 28;
   localparam logic [NUM_W-1:0] LIMIT_HIGH = 49'd216268800;
   localparam logic [NUM_W-1:0] SEG1_TOP   = 49'd29360128;
   localparam int SEG2_TOP_INT = 95485952;
   localparam logic [NUM_W-1:0] SEG2_TOP   = NUM_W'(SEG2_TOP_INT);

   // Segment product and rounding.
   localparam int KC_W        = 38;
   localparam int SLOPE_W     = 10;
   localparam int Y_SIG_W     = 23;
   localparam int ROUND_SHIFT = 16;
   localparam logic signed [EC_W-1:0] Q_BIAS = 16'sd64;

   // Range status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HIGH = 2'd2;

   // Input and result words.
   typedef struct packed {
      logic        [ADC_W-1:0]  adc_sample;
      logic signed [TEMP_W-1:0] temperature_q4;
   } tcec_req_type;

   typedef struct packed {
      logic signed [EC_W-1:0]     ec_us;
      logic        [STATUS_W-1:0] range_status;
   } tcec_rsp_type;

   // Kind of result that the controller asks the datapath to emit.
   typedef enum logic [1:0] {
      KIND_SEG,
      KIND_LOW,
      KIND_HIGH
   } tcec_kind_type;

   // Linear segment of the conductivity curve.
   typedef enum logic [1:0] {
      SEG_LOW,
      SEG_MID,
      SEG_HIGH
   } tcec_seg_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCALE,
      ST_LOAD1,
      ST_DIV1,
      ST_RANGE,
      ST_LOAD2,
      ST_OUT
   } tcec_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          start;
      logic          prep;
      logic          scale;
      logic          load1;
      logic          step;
      logic          seg_mul;
      logic          load2;
      logic          out_load;
      tcec_kind_type kind;
   } tcec_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic d_fail;
      logic above;
      logic div_done;
      logic out_free;
   } tcec_stat_type;

   // Slope of each segment, scaled by 100.
   function automatic logic [SLOPE_W-1:0] seg_slope(input tcec_seg_type seg);
      logic [SLOPE_W-1:0] slope;
      unique case (seg)
         SEG_LOW:  slope = 10'd684;
         SEG_MID:  slope = 10'd698;
         SEG_HIGH: slope = 10'd530;
         default:  slope = 10'd0;
      endcase
      return slope;
   endfunction

   // Intercept of each segment scaled by 100, plus the rounding half (50)
   // and a bias of 6400 that keeps the dividend of the final divide positive.
   function automatic logic signed [Y_SIG_W-1:0] seg_bias(input tcec_seg_type seg);
      logic signed [Y_SIG_W-1:0] bias;
      unique case (seg)
         SEG_LOW:  bias = 23'sd18;
         SEG_MID:  bias = -23'sd6250;
         SEG_HIGH: bias = 23'sd234250;
         default:  bias = 23'sd0;
      endcase
      return bias;
   endfunction

endpackage

// ===== src/tcec_ctrl.sv =====
// Controller state machine that sequences one conversion through the datapath.
module tcec_ctrl import tcec_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  tcec_stat_type stat,
   output tcec_cmd_type  cmd,
   output logic          busy
);

   tcec_state_type state_ff, state_in;
   tcec_kind_type  kind_ff, kind_in;

   // State and result kind registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= KIND_SEG;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (stat.d_fail) begin
               kind_in  = KIND_LOW;
               state_in = ST_OUT;
            end else begin
               state_in = ST_LOAD1;
            end
         end
         ST_LOAD1: begin
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            if (stat.div_done) begin
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            if (stat.above) begin
               kind_in  = KIND_HIGH;
               state_in = ST_OUT;
            end else begin
               state_in = ST_LOAD2;
            end
         end
         ST_LOAD2: begin
            kind_in  = KIND_SEG;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd.start    = 1'b0;
      cmd.prep     = 1'b0;
      cmd.scale    = 1'b0;
      cmd.load1    = 1'b0;
      cmd.step     = 1'b0;
      cmd.seg_mul  = 1'b0;
      cmd.load2    = 1'b0;
      cmd.out_load = 1'b0;
      cmd.kind     = kind_ff;
      unique case (state_ff)
         ST_IDLE:  cmd.start    = start;
         ST_PREP:  cmd.prep     = 1'b1;
         ST_SCALE: cmd.scale    = 1'b1;
         ST_LOAD1: cmd.load1    = 1'b1;
         ST_DIV1:  cmd.step     = !stat.div_done;
         ST_RANGE: cmd.seg_mul  = !stat.above;
         ST_LOAD2: cmd.load2    = 1'b1;
         ST_OUT:   cmd.out_load = stat.out_free;
         default:  cmd.start    = 1'b0;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== src/tcec_dpath.sv =====
// Datapath: coefficient and dividend multipliers, serial divider, segment map
// and result register.
module tcec_dpath import tcec_pkg::*; #(
   parameter int SAMPLES = SAMPLES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tcec_cmd_type               cmd,
   output tcec_stat_type              stat,
   input  logic        [SUM_W-1:0]    start_sum,
   input  logic signed [TEMP_W-1:0]   start_temp,
   input  logic signed [OFFSET_W-1:0] offset,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tcec_rsp_type               rsp_word
);

   logic        [SUM_W-1:0]  sum_ff;
   logic signed [TEMP_W-1:0] temp_ff;
   logic signed [D_W-1:0]    d_ff, d_in;
   logic        [PROD_W-1:0] prod_ff, prod_in;
   logic        [DIVR_W-1:0] div_ff, div_in;
   logic        [DIVR_W-1:0] rem_ff, rem_in;
   logic        [NUM_W-1:0]  num_ff, num_in;
   logic        [DCNT_W-1:0] dcnt_ff, dcnt_in;
   tcec_seg_type             seg_ff, seg_in;
   logic        [KC_W-1:0]   kc_ff, kc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   tcec_rsp_type             rsp_word_ff, rsp_word_in;

   logic signed [D_W-1:0]     temp_ext;
   logic                      d_pos;
   logic        [DIVR_W+1:0]  trial;
   logic                      fits;
   logic signed [Y_SIG_W-1:0] y_sig;
   logic        [RECIP_W-1:0] recip_prod;
   logic signed [EC_W-1:0]    ec_value;

   // Coefficient D and the scaled dividend.
   always_comb begin
      temp_ext = D_W'(temp_ff);
      d_in     = temp_ext * D_SLOPE + D_BIAS;
      prod_in  = PROD_W'(sum_ff) * PROD_W'(VOLT_MULT);
   end

   // A zero coefficient fails, as does a negative one unless the sum is zero; a
   // zero sum then divides by an all-ones divisor and so yields a zero voltage.
   assign d_pos       = !d_ff[D_W-1] && (d_ff != '0);
   assign stat.d_fail = (d_ff == '0) || (d_ff[D_W-1] && (sum_ff != '0));

   // One restoring division step: bring down the next dividend bit, subtract
   // when the divisor fits and shift the quotient bit in at the bottom.
   // The load2 command loads the biased segment value divided by 100 into num.
   always_comb begin
      trial  = {1'b0, rem_ff, num_ff[NUM_W-1]} - {2'b00, div_ff};
      fits   = !trial[DIVR_W+1];
      div_in = div_ff;
      rem_in = rem_ff;
      num_in = num_ff;
      dcnt_in = dcnt_ff;
      if (cmd.scale) begin
         div_in = d_pos ? DIVR_W'(d_ff[D_W-2:0]) * DIVR_W'(SAMPLES) : '1;
      end
      if (cmd.load1) begin
         rem_in  = '0;
         num_in  = {prod_ff, VOLT_SHIFT'(0)};
         dcnt_in = DCNT_W'(DIV1_STEPS);
      end else if (cmd.load2) begin
         num_in  = NUM_W'(recip_prod[RECIP_W-1:RECIP_SHIFT]);
      end else if (cmd.step) begin
         rem_in  = fits ? trial[DIVR_W-1:0] : {rem_ff[DIVR_W-2:0], num_ff[NUM_W-1]};
         num_in  = {num_ff[NUM_W-2:0], fits};
         dcnt_in = dcnt_ff - 1'b1;
      end
   end

   assign stat.div_done = (dcnt_ff == '0);
   assign stat.above    = (num_ff > LIMIT_HIGH);

   // Segment choice and slope product on the compensated voltage.
   always_comb begin
      if (num_ff <= SEG1_TOP) begin
         seg_in = SEG_LOW;
      end else if (num_ff <= SEG2_TOP) begin
         seg_in = SEG_MID;
      end else begin
         seg_in = SEG_HIGH;
      end
      kc_in = KC_W'(seg_slope(seg_in)) * KC_W'(num_ff[V_W-1:0]);
   end

   // Rounded segment value times 100, biased positive for the final divide.
   assign y_sig = signed'({1'b0, kc_ff[KC_W-1:ROUND_SHIFT]}) + seg_bias(seg_ff);

   // Division by 100 as a multiply by the scaled reciprocal.
   assign recip_prod = RECIP_W'(y_sig[Y_W-1:0]) * RECIP_W'(SEG_RECIP);

   // Result word selection.
   always_comb begin
      ec_value = signed'(EC_W'(num_ff[EC_W-1:0])) - Q_BIAS
               + signed'({{(EC_W-OFFSET_W){offset[OFFSET_W-1]}}, offset});
      case (cmd.kind)
         KIND_SEG: begin
            rsp_word_in.ec_us        = ec_value;
            rsp_word_in.range_status = STATUS_OK;
         end
         KIND_LOW: begin
            rsp_word_in.ec_us        = '0;
            rsp_word_in.range_status = STATUS_LOW;
         end
         KIND_HIGH: begin
            rsp_word_in.ec_us        = '0;
            rsp_word_in.range_status = STATUS_HIGH;
         end
         default: begin
            rsp_word_in.ec_us        = '0;
            rsp_word_in.range_status = STATUS_LOW;
         end
      endcase
   end

   // The result register may load when empty or when its word leaves now.
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         dcnt_ff      <= dcnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         sum_ff  <= start_sum;
         temp_ff <= start_temp;
      end
      if (cmd.prep) begin
         d_ff    <= d_in;
         prod_ff <= prod_in;
      end
      if (cmd.seg_mul) begin
         seg_ff <= seg_in;
         kc_ff  <= kc_in;
      end
      if (cmd.out_load) begin
         rsp_word_ff <= rsp_word_in;
      end
      div_ff <= div_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== src/temperature_compensated_ec.sv =====
// Usage: converter readings come in on the req_ channel (req_valid, req_stall,
// req_word) and one conductivity word per group of SAMPLES readings leaves on
// the rsp_ channel (rsp_valid, rsp_stall, rsp_word). A word moves at a rising
// clock edge with valid high and stall low. The temperature of a group is
// taken from its last reading. csr_wr_en with csr_wr_data writes the signed
// calibration offset, to be done only while no group is in conversion.
// Every reading but the last of a group is taken without a stall. The last
// one starts a conversion; a word in range is offered after three setup
// states, the 49-step restoring divide of the compensated voltage, the
// segment multiply, the reciprocal multiply that divides by 100 and the
// result register load. Readings of the next group keep flowing in during a
// conversion; only the next group's last reading is stalled until the
// converter is free. When rsp_stall holds the result register full, the
// converter waits with its result and the input stalls at the following
// last reading. Reset clears the sum and count, empties the result
// register and sets the offset to 150 uS/cm.
module temperature_compensated_ec import tcec_pkg::*; #(
   parameter int SAMPLES = SAMPLES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  tcec_req_type               req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tcec_rsp_type               rsp_word,
   input  logic                       csr_wr_en,
   input  logic signed [OFFSET_W-1:0] csr_wr_data
);

   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES - 1);

   logic signed [OFFSET_W-1:0] offset_ff;
   logic        [SUM_W-1:0]    sum_ff, sum_in;
   logic        [CNT_W-1:0]    count_ff, count_in;
   logic                       is_last;
   logic                       accept;
   logic                       start;
   logic                       busy;
   tcec_cmd_type               cmd;
   tcec_stat_type              stat;

   // A last reading waits while the converter still holds the previous group.
   assign is_last   = (count_ff == LAST_COUNT);
   assign req_stall = is_last && busy;
   assign accept    = req_valid && !req_stall;
   assign start     = accept && is_last;

   // Group accumulator; it clears when the group is handed to the converter.
   always_comb begin
      sum_in   = sum_ff + SUM_W'(req_word.adc_sample);
      count_in = count_ff + 1'b1;
      if (is_last) begin
         sum_in   = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else if (accept) begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   // Calibration offset register.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else if (csr_wr_en) begin
         offset_ff <= csr_wr_data;
      end
   end

   tcec_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   tcec_dpath #(
      .SAMPLES (SAMPLES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .start_sum  (sum_ff + SUM_W'(req_word.adc_sample)),
      .start_temp (req_word.temperature_q4),
      .offset     (offset_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule

// ===== tb/sv/tcec_conversion_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts the conductivity word of each group of readings and compares it.
module tcec_conversion_checker import tcec_pkg::*; #(
   parameter int SAMPLES = SAMPLES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  tcec_req_type               req_word,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  tcec_rsp_type               rsp_word,
   input  logic                       csr_wr_en,
   input  logic signed [OFFSET_W-1:0] csr_wr_data,
   output int                         errors,
   output int                         pending,
   output int                         checked,
   output int                         n_ok,
   output int                         n_low,
   output int                         n_high
);

   // Fixed-point constants of the conversion, all in 64-bit arithmetic.
   localparam longint Q16        = 65536;
   localparam longint COEF_SLOPE = 37;
   localparam longint COEF_BIAS  = 17200;
   localparam longint VOLT_NUM   = 64'd10240000000;
   localparam longint V_LIMIT    = 3300 * Q16;
   localparam longint V_KNEE_LOW = 448 * Q16;
   localparam longint V_KNEE_MID = 1457 * Q16;
   localparam longint SLOPE_LOW  = 684;
   localparam longint SLOPE_MID  = 698;
   localparam longint SLOPE_HIGH = 530;
   localparam longint ICPT_LOW   = -6432 * Q16;
   localparam longint ICPT_MID   = -12700 * Q16;
   localparam longint ICPT_HIGH  = 227800 * Q16;
   localparam longint SEG_SCALE  = 6553600;

   logic [SUM_W-1:0]          run_sum;
   int                        run_count;
   logic signed [OFFSET_W-1:0] cal_offset;
   tcec_rsp_type              awaited[$];

   // Division to the nearest integer with ties going up; the divisor is positive.
   function automatic longint round_half_up(input longint num, input longint den);
      longint n;
      longint q;
      n = num + den / 2;
      q = n / den;
      if (n < 0 && (n % den) != 0) q = q - 1;
      return q;
   endfunction

   // Expected word for a finished group: compensated voltage, range check, segment.
   function automatic tcec_rsp_type convert_group(input logic [SUM_W-1:0] sum,
                                                  input logic signed [TEMP_W-1:0] temp,
                                                  input logic signed [OFFSET_W-1:0] offset);
      tcec_rsp_type r;
      longint coef;
      longint volt;
      longint lin;
      r.ec_us = '0;
      r.range_status = STATUS_LOW;
      coef = COEF_SLOPE * longint'(temp) + COEF_BIAS;
      if (coef == 0) return r;
      if (coef < 0) begin
         // A negative coefficient only has a solution for a zero sum.
         if (sum != 0) return r;
         volt = 0;
      end else begin
         volt = (longint'(sum) * VOLT_NUM) / (longint'(SAMPLES) * coef);
      end
      if (volt > V_LIMIT) begin
         r.range_status = STATUS_HIGH;
         return r;
      end
      if (volt <= V_KNEE_LOW)
         lin = round_half_up(SLOPE_LOW * volt + ICPT_LOW, SEG_SCALE);
      else if (volt <= V_KNEE_MID)
         lin = round_half_up(SLOPE_MID * volt + ICPT_MID, SEG_SCALE);
      else
         lin = round_half_up(SLOPE_HIGH * volt + ICPT_HIGH, SEG_SCALE);
      r.ec_us = EC_W'(lin + longint'(offset));
      r.range_status = STATUS_OK;
      return r;
   endfunction

   // Prints one line per mismatch and counts it.
   task automatic report(input string what);
      errors++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   // Everything is sampled at the rising edge; inputs move at the falling edge.
   always @(posedge clock) begin : watch
      tcec_rsp_type want;
      if (reset) begin
         run_sum = '0;
         run_count = 0;
         cal_offset = OFFSET_RESET;
         awaited.delete();
      end else begin
         // The user must let offset writes land only while the converter is idle.
         if (csr_wr_en) cal_offset = csr_wr_data;

         // Readings add up; the last one of a group yields one expected word.
         if (req_valid && !req_stall) begin
            run_sum = run_sum + SUM_W'(req_word.adc_sample);
            if (run_count + 1 < SAMPLES) begin
               run_count++;
            end else begin
               want = convert_group(run_sum, req_word.temperature_q4, cal_offset);
               awaited.push_back(want);
               case (want.range_status)
                  STATUS_OK:   n_ok++;
                  STATUS_HIGH: n_high++;
                  default:     n_low++;
               endcase
               run_sum = '0;
               run_count = 0;
            end
         end

         // Each result word is compared with the oldest expected word.
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               report($sformatf("word with nothing expected: ec_us=%0d status=%0d",
                                rsp_word.ec_us, rsp_word.range_status));
            end else begin
               want = awaited.pop_front();
               checked++;
               if (rsp_word.ec_us !== want.ec_us)
                  report($sformatf("ec_us got %0d, expected %0d (status %0d)",
                                   rsp_word.ec_us, want.ec_us, want.range_status));
               if (rsp_word.range_status !== want.range_status)
                  report($sformatf("range_status got %0d, expected %0d",
                                   rsp_word.range_status, want.range_status));
            end
         end
      end
      pending <= awaited.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the converter testbench: clock, reset, stimulus, output pacing and verdict.
module tb_top import tcec_pkg::*;;

   localparam int SAMPLES          = SAMPLES_DEFAULT;
   localparam int FULL_SUM         = 1023 * SAMPLES;
   localparam int GROUPS_PER_PHASE = 10;
   localparam int SETTLE_CYCLES    = 100;
   localparam int HOLD_CYCLES      = 600;
   localparam int CYCLE_LIMIT      = 200000;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   tcec_req_type                req_word;
   logic                        rsp_valid;
   logic                        rsp_stall;
   tcec_rsp_type                rsp_word;
   logic                        csr_wr_en;
   logic signed [OFFSET_W-1:0]  csr_wr_data;

   int errors, pending, checked, n_ok, n_low, n_high;
   int readings_sent;
   bit calm;
   bit squeeze;

   temperature_compensated_ec #(.SAMPLES(SAMPLES)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tcec_conversion_checker #(.SAMPLES(SAMPLES)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .errors      (errors),
      .pending     (pending),
      .checked     (checked),
      .n_ok        (n_ok),
      .n_low       (n_low),
      .n_high      (n_high)
   );

   // 20 ns clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Offers one reading after a random gap, none in calm phases, and holds it until it is taken.
   task automatic send_reading(input tcec_req_type w);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      readings_sent++;
      @(negedge clock);
   endtask

   // A group whose readings add up to a chosen total, with a chosen last temperature.
   task automatic send_group(input int total, input logic signed [TEMP_W-1:0] last_temp);
      tcec_req_type w;
      for (int i = 0; i < SAMPLES; i++) begin
         w.adc_sample = ADC_W'(total / SAMPLES + ((i < total % SAMPLES) ? 1 : 0));
         w.temperature_q4 = (i == SAMPLES - 1) ? last_temp : TEMP_W'($urandom);
         send_reading(w);
      end
   endtask

   // A group of random readings at most a random cap; the last temperature is
   // mostly in the working range, sometimes anywhere in the field.
   task automatic send_random_group();
      tcec_req_type w;
      int cap;
      cap = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, 1023);
      for (int i = 0; i < SAMPLES; i++) begin
         w.adc_sample = ADC_W'($urandom_range(0, cap));
         if (i == SAMPLES - 1 && $urandom_range(0, 3) != 0)
            w.temperature_q4 = TEMP_W'(int'($urandom_range(0, 2880)) - 880);
         else
            w.temperature_q4 = TEMP_W'($urandom);
         send_reading(w);
      end
   endtask

   // Waits until every expected word has come, then lets the converter settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One write of the calibration offset.
   task automatic write_offset(input logic signed [OFFSET_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Output side: a random stall before each word, none in calm phases, and one
   // long hold so that the converter backs up into the input.
   initial begin : rsp_side
      int gap;
      bit squeezed;
      rsp_stall = 1'b0;
      squeezed = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (squeeze && !squeezed) begin
            gap = HOLD_CYCLES;
            squeezed = 1'b1;
         end else begin
            gap = calm ? 0 : $urandom_range(0, 4);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Ends the run if it takes far longer than the slowest correct run.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles with %0d words outstanding", cycles, pending);
      $display("Verification failed");
      $finish;
   end

   // Stimulus: directed groups, then random phases under several offsets.
   initial begin : stimulus
      logic signed [OFFSET_W-1:0] offsets[6];
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      calm = 1'b0;
      squeeze = 1'b0;
      readings_sent = 0;
      offsets[0] = -12'sd2048;
      offsets[1] = 12'sd2047;
      offsets[2] = -12'sd2000;
      offsets[3] = 12'sd2000;
      offsets[4] = 12'sd0;
      offsets[5] = OFFSET_W'(int'($urandom_range(0, 4000)) - 2000);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed groups under the reset offset: negative coefficient with zero
      // and nonzero sums, above range, both sides of each knee and of the upper
      // limit at 25 degC, the hottest and a nearly vanishing coefficient.
      send_group(0, -12'sd2048);
      send_group(FULL_SUM, -12'sd2048);
      send_group(FULL_SUM, 12'sd0);
      send_group(1835, 12'sd400);
      send_group(1836, 12'sd400);
      send_group(5967, 12'sd400);
      send_group(5968, 12'sd400);
      send_group(13516, 12'sd400);
      send_group(13517, 12'sd400);
      send_group(FULL_SUM, 12'sd2047);
      send_group(1, -12'sd464);
      send_group(1, -12'sd465);
      for (int g = 0; g < GROUPS_PER_PHASE; g++) send_random_group();

      // Random phases; the first carries the long output hold, some run calm.
      for (int p = 0; p < 6; p++) begin
         wait_drained();
         write_offset(offsets[p]);
         calm = (p == 2 || p == 4);
         squeeze = (p == 0) || squeeze;
         for (int g = 0; g < GROUPS_PER_PHASE; g++) send_random_group();
      end

      wait_drained();
      $display("Summary: %0d readings sent, %0d words checked (%0d in range, %0d low, %0d high).",
               readings_sent, checked, n_ok, n_low, n_high);
      $display("Offsets from -2048 to 2047 were used, with paced, calm and held-output phases.");
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", errors);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/tcec_pkg.sv
src/tcec_ctrl.sv
src/tcec_dpath.sv
src/temperature_compensated_ec.sv
tb/sv/tcec_conversion_checker.sv
tb/sv/tb_top.sv
